[sv/pitas_pkg.sv]
// Package: shared types and constants for the angle-sum point-in-triangle test.
package pitas_pkg;
  localparam int CoordW  = 16;
  localparam int VecW    = 17;
  localparam int ProdW   = 36;
  localparam int ZW      = 34;
  localparam int AngW    = 17;
  localparam int MaxStg  = 24;
  localparam logic [ZW-1:0] PiQ30     = 34'd3373259426;
  localparam logic [ZW-1:0] TinyQ30   = 34'd187404;
  localparam logic [ZW-1:0] NearPiQ30 = 34'd3373072023;
  localparam logic signed [AngW-1:0] PiQ13 = 17'sd25736;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [ProdW-1:0] prod_t;

  // CORDIC cell state handed from cell to cell, one per angle pair.
  typedef struct packed {
    logic        zero;    // angle forced to zero
    logic        pi;      // angle forced to pi
    logic        neg_dot; // reflect result about pi
    logic        neg_crs; // negate final angle
    prod_t       x;
    prod_t       y;
    logic signed [ZW:0] z;
  } cell_t;

  function automatic logic [ZW-1:0] atan_q30(input int i);
    logic [ZW-1:0] t;
    case (i)
      0: t = 34'd843314856;   1: t = 34'd497837829;
      2: t = 34'd263043836;   3: t = 34'd133525158;
      4: t = 34'd67021686;    5: t = 34'd33543515;
      6: t = 34'd16775850;    7: t = 34'd8388437;
      8: t = 34'd4194282;     9: t = 34'd2097149;
      10: t = 34'd1048575;    11: t = 34'd524287;
      12: t = 34'd262143;     13: t = 34'd131071;
      14: t = 34'd65535;      15: t = 34'd32767;
      16: t = 34'd16383;      17: t = 34'd8191;
      18: t = 34'd4095;       19: t = 34'd2047;
      20: t = 34'd1023;       21: t = 34'd511;
      22: t = 34'd255;        23: t = 34'd127;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage

[sv/pitas_if.sv]
// Interfaces: valid/ready channels for query words and result words.
interface pitas_in_if;
  import pitas_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x, point_y;
  coord_t corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y;
  modport source (output valid, point_x, point_y, corner_a_x, corner_a_y,
                  corner_b_x, corner_b_y, corner_c_x, corner_c_y, input ready);
  modport sink (input valid, point_x, point_y, corner_a_x, corner_a_y,
                corner_b_x, corner_b_y, corner_c_x, corner_c_y, output ready);
endinterface

interface pitas_out_if;
  logic              valid;
  logic              ready;
  logic              inside_res;
  logic signed [16:0] angle_sum;
  modport source (output valid, inside_res, angle_sum, input ready);
  modport sink (input valid, inside_res, angle_sum, output ready);
endinterface

[sv/pitas_cell.sv]
// CORDIC cell: one vectoring rotation on three angle pairs at once.
module pitas_cell #(
  parameter int Idx = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  pitas_pkg::cell_t [2:0] d_in,
  output pitas_pkg::cell_t [2:0] d_out
);
  import pitas_pkg::*;
  cell_t [2:0] q_nxt;
  cell_t [2:0] q_r;
  localparam logic [ZW:0] At = {1'b0, atan_q30(Idx)};

  always_comb begin
    q_nxt = d_in;
    for (int k = 0; k < 3; k++) begin
      if (!d_in[k].y[ProdW-1]) begin
        q_nxt[k].x = d_in[k].x + (d_in[k].y >>> Idx);
        q_nxt[k].y = d_in[k].y - (d_in[k].x >>> Idx);
        q_nxt[k].z = d_in[k].z + $signed(At);
      end else begin
        q_nxt[k].x = d_in[k].x - (d_in[k].y >>> Idx);
        q_nxt[k].y = d_in[k].y + (d_in[k].x >>> Idx);
        q_nxt[k].z = d_in[k].z - $signed(At);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end
  assign d_out = q_r;
endmodule

[sv/point_in_triangle_angle_sum.sv]
// Top level: pipelined angle-sum point-in-triangle test.
//
// One query word enters per clock and one result word leaves per clock
// once the pipe is full and words are taken. In order, one stage
// forms the corner-to-point vectors, one forms the dot and cross products,
// one sets up the CORDIC inputs, then a chain of CORDIC_STAGES cells each
// performs one rotation for all three corner pairs, and one stage rounds,
// signs and sums the angles into the output register. The whole pipe
// advances together and holds while a finished word waits downstream, so
// throughput is one word per cycle whenever the consumer takes words.
// CORDIC_STAGES above 24 acts as 24.
module point_in_triangle_angle_sum #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst_n,
  pitas_in_if.sink    in_ch,
  pitas_out_if.source out_ch
);
  import pitas_pkg::*;
  localparam int Stg = (CORDIC_STAGES > MaxStg) ? MaxStg : CORDIC_STAGES;
  localparam int Lat = Stg + 4;

  logic [Lat-1:0] vld_r;
  logic           adv;

  // Advance whenever the output slot is empty or being drained.
  assign adv = !vld_r[Lat-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Lat-2:0], in_ch.valid};
    end
  end

  // Stage 1: vectors from each corner to the point.
  vec_t vx_r [3];
  vec_t vy_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r[0] <= VecW'(in_ch.point_x) - VecW'(in_ch.corner_a_x);
      vy_r[0] <= VecW'(in_ch.point_y) - VecW'(in_ch.corner_a_y);
      vx_r[1] <= VecW'(in_ch.point_x) - VecW'(in_ch.corner_b_x);
      vy_r[1] <= VecW'(in_ch.point_y) - VecW'(in_ch.corner_b_y);
      vx_r[2] <= VecW'(in_ch.point_x) - VecW'(in_ch.corner_c_x);
      vy_r[2] <= VecW'(in_ch.point_y) - VecW'(in_ch.corner_c_y);
    end
  end

  // Stage 2: dot and cross for each cyclic pair.
  prod_t dot_r [3];
  prod_t crs_r [3];
  logic  zv_r  [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        dot_r[k] <= ProdW'(vx_r[k] * vx_r[(k+1)%3]) + ProdW'(vy_r[k] * vy_r[(k+1)%3]);
        crs_r[k] <= ProdW'(vx_r[k] * vy_r[(k+1)%3]) - ProdW'(vy_r[k] * vx_r[(k+1)%3]);
        zv_r[k]  <= (vx_r[k] == '0 && vy_r[k] == '0) ||
                    (vx_r[(k+1)%3] == '0 && vy_r[(k+1)%3] == '0);
      end
    end
  end

  // Stage 3: CORDIC setup on magnitudes.
  cell_t [2:0] chain [Stg+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        chain[0][k].zero    <= zv_r[k] || (crs_r[k] == '0 && !dot_r[k][ProdW-1]);
        chain[0][k].pi      <= !zv_r[k] && crs_r[k] == '0 && dot_r[k][ProdW-1];
        chain[0][k].neg_dot <= dot_r[k][ProdW-1];
        chain[0][k].neg_crs <= crs_r[k][ProdW-1];
        chain[0][k].x <= dot_r[k][ProdW-1] ? -dot_r[k] : dot_r[k];
        chain[0][k].y <= crs_r[k][ProdW-1] ? -crs_r[k] : crs_r[k];
        chain[0][k].z <= '0;
      end
    end
  end

  for (genvar g = 0; g < Stg; g++) begin : g_cell
    pitas_cell #(.Idx(g)) u_cell (
      .clk  (clk),
      .en   (adv),
      .d_in (chain[g]),
      .d_out(chain[g+1])
    );
  end

  // Final stage: fix up, round, sign and sum.
  logic signed [AngW-1:0] ang [3];
  logic signed [ZW+1:0]   a_full [3];
  logic signed [AngW+1:0] sum;
  logic signed [AngW+1:0] mag;
  logic                   inside_nxt;
  logic signed [AngW-1:0] sum_nxt;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_full[k] = chain[Stg][k].neg_dot ?
                  $signed({2'b00, PiQ30}) - (ZW+2)'(chain[Stg][k].z) :
                  (ZW+2)'(chain[Stg][k].z);
      if (chain[Stg][k].zero || a_full[k] < $signed({2'b00, TinyQ30})) begin
        ang[k] = '0;
      end else if (chain[Stg][k].pi || a_full[k] >= $signed({2'b00, NearPiQ30})) begin
        ang[k] = PiQ13;
      end else begin
        ang[k] = AngW'((a_full[k] + (ZW+2)'(65536)) >>> 17);
      end
      if (chain[Stg][k].neg_crs) begin
        ang[k] = -ang[k];
      end
    end
    sum = (AngW+2)'(ang[0]) + (AngW+2)'(ang[1]) + (AngW+2)'(ang[2]);
    mag = sum[AngW+1] ? -sum : sum;
    inside_nxt = mag > (AngW+2)'(PiQ13);
    if (sum < -(AngW+2)'(65536)) begin
      sum_nxt = 17'sh10000;
    end else if (sum > (AngW+2)'(65535)) begin
      sum_nxt = 17'sh0FFFF;
    end else begin
      sum_nxt = AngW'(sum);
    end
  end

  logic                   inside_r;
  logic signed [AngW-1:0] sum_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      inside_r <= inside_nxt;
      sum_r    <= sum_nxt;
    end
  end

  assign out_ch.valid      = vld_r[Lat-1];
  assign out_ch.inside_res = inside_r;
  assign out_ch.angle_sum  = sum_r;

`ifndef SYNTH
  // A stalled result word must keep its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.angle_sum))
    else $error("result word changed while stalled");
  // Input is refused only when the output slot is full and stalled.
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("pipe stalled without backpressure");
  // inside implies a sum magnitude above pi.
  a_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.inside_res |->
      (out_ch.angle_sum > PiQ13 || out_ch.angle_sum < -PiQ13))
    else $error("inside flag inconsistent with sum");
`endif
endmodule
